>>> src/spba_pkg.sv
package spba_pkg;

  localparam int unsigned MaxEquations = 1024;
  localparam int unsigned ProfileDepth = 65536;
  localparam int unsigned LocW = 17;
  localparam logic [LocW-1:0] LocMax = 17'h1FFFF;
  localparam int unsigned ValW = 48;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_EDGE     = 3'd1,
    MODE_FINALIZE = 3'd2,
    MODE_ADD      = 3'd3,
    MODE_CLEAR    = 3'd4,
    MODE_READ     = 3'd5,
    MODE_RSVD6    = 3'd6,
    MODE_RSVD7    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_HCLR,
    S_EDGE_RD,
    S_EDGE_WR,
    S_FIN_RD,
    S_FIN,
    S_SCLR,
    S_ADR_RD,
    S_ADR_CHK,
    S_MUL,
    S_ST_RD,
    S_ST_WR,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic     load;      // capture input item
    logic     hclr_step; // clear one height
    logic     dclr;      // clear one diagonal location (after reset)
    logic     edge_rd;
    logic     edge_wr;
    logic     fin_rd;    // read height of column cnt
    logic     fin_step;  // one column of prefix sum
    logic     fin_init;
    logic     sclr_step; // clear one store entry
    logic     cnt_clr;
    logic     adr_rd;    // read diag(col), diag(col-1)
    logic     adr_chk;
    logic     mul;
    logic     st_rd;
    logic     st_wr;
    logic     set_status;
    status_e  status;
    logic     out_load;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic    cnt_last_h;  // height sweep done
    logic    cnt_last_f;  // finalize sweep done (or n==0)
    logic    cnt_last_s;  // store sweep done
    logic    range_bad;   // edge col out of range
    logic    ar_bad;      // add/read row or col out of range
    logic    scale_zero;
    logic    outside;
    logic    over;
    mode_e   mode;
  } stat_t;

endpackage

>>> src/spba_ctrl.sv
module spba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_busy_i,
  input  spba_pkg::stat_t st_i,
  output spba_pkg::ctrl_t ctl_o
);
  import spba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    ctl_o.status = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        // clearing pass after reset: heights and diagonal locations
        ctl_o.hclr_step = 1'b1;
        ctl_o.dclr      = 1'b1;
        if (st_i.cnt_last_h) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load    = 1'b1;
          ctl_o.cnt_clr = 1'b1;
          state_d       = S_DONE;
          priority case (st_i.mode)
            MODE_START:    state_d = S_HCLR;
            MODE_EDGE:     state_d = S_EDGE_RD;
            MODE_FINALIZE: state_d = S_FIN_RD;
            MODE_ADD,
            MODE_READ:     state_d = S_ADR_RD;
            MODE_CLEAR:    state_d = S_SCLR;
            default:       state_d = S_DONE;
          endcase
          ctl_o.fin_init   = 1'b1;
          ctl_o.set_status = 1'b1;
          ctl_o.status     = (st_i.mode == MODE_RSVD6 || st_i.mode == MODE_RSVD7)
                             ? ST_OUTSIDE : ST_OK;
        end
      end
      S_HCLR: begin
        ctl_o.hclr_step = 1'b1;
        if (st_i.cnt_last_h) state_d = S_DONE;
      end
      S_EDGE_RD: begin
        if (st_i.range_bad) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = ST_RANGE;
          state_d          = S_DONE;
        end else begin
          ctl_o.edge_rd = 1'b1;
          state_d       = S_EDGE_WR;
        end
      end
      S_EDGE_WR: begin
        ctl_o.edge_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_FIN_RD: begin
        if (st_i.cnt_last_f) begin
          ctl_o.cnt_clr = 1'b1;
          state_d       = S_SCLR;
        end else begin
          ctl_o.fin_rd = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        ctl_o.fin_step = 1'b1;
        state_d        = S_FIN_RD;
      end
      S_SCLR: begin
        ctl_o.sclr_step = 1'b1;
        if (st_i.cnt_last_s) begin
          if (st_i.over && st_i.mode == MODE_FINALIZE) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status     = ST_OVERFLOW;
          end
          state_d = S_DONE;
        end
      end
      S_ADR_RD: begin
        if (st_i.mode == MODE_ADD && st_i.scale_zero) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = ST_OUTSIDE;
          state_d          = S_DONE;
        end else if (st_i.ar_bad) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = ST_RANGE;
          state_d          = S_DONE;
        end else begin
          ctl_o.adr_rd = 1'b1;
          state_d      = S_ADR_CHK;
        end
      end
      S_ADR_CHK: begin
        ctl_o.adr_chk = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        if (st_i.outside) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status     = ST_OUTSIDE;
          state_d          = S_DONE;
        end else begin
          ctl_o.mul   = 1'b1;
          ctl_o.st_rd = 1'b1;
          state_d     = S_ST_RD;
        end
      end
      S_ST_RD: begin
        state_d = (st_i.mode == MODE_ADD) ? S_ST_WR : S_DONE;
      end
      S_ST_WR: begin
        ctl_o.st_wr = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_busy_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.st_wr |-> $past(state_q) == S_ST_RD)
    else $error("store write without read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> state_q != S_IDLE)
    else $error("accepted item lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> !out_busy_i)
    else $error("result overwritten");
endmodule

>>> src/spba_dpath.sv
module spba_dpath #(
  parameter int unsigned MaxEq = spba_pkg::MaxEquations,
  parameter int unsigned Depth = spba_pkg::ProfileDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spba_pkg::ctrl_t ctl_i,
  output spba_pkg::stat_t st_o,
  input  logic [10:0]     num_eq_i,
  input  logic [2:0]      mode_i,
  input  logic [9:0]      row_i,
  input  logic [9:0]      col_i,
  input  logic [31:0]     val_i,
  input  logic [31:0]     scl_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [1:0]      status_o,
  output logic [47:0]     read_o,
  output logic [16:0]     total_o
);
  import spba_pkg::*;

  localparam int unsigned EqW = (MaxEq > 1) ? $clog2(MaxEq) : 1;
  localparam int unsigned AdW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = 25;
  localparam logic [47:0] VMax = {1'b0, {47{1'b1}}};
  localparam logic [47:0] VMin = {1'b1, 47'b0};

  logic [9:0]      height_mem [MaxEq];
  logic [LocW-1:0] diag_mem   [MaxEq];
  logic [47:0]     store_mem  [Depth];

  mode_e       mode_q;
  logic [9:0]  row_q, col_q;
  logic [31:0] val_q, scl_q;
  logic [10:0] n_q;
  logic [CntW-1:0] cnt_q;
  logic [LocW-1:0] total_q, psize_q, dcol_q, dprev_q;
  logic        over_q, outside_q;
  status_e     status_q;
  logic [9:0]  hrd_q;
  logic signed [63:0] prod_q;
  logic [AdW-1:0] addr_q;
  logic [47:0] srd_q;
  logic        ovalid_q;
  logic [47:0] ord_q;
  logic [1:0]  ost_q;
  logic [16:0] ot_q;
  logic [LocW-1:0] hnext;

  // effective count
  logic [10:0] n_eff;
  assign n_eff = (num_eq_i > 11'(MaxEq)) ? 11'(MaxEq) : num_eq_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q <= mode_e'(mode_i);
      row_q  <= row_i;
      col_q  <= col_i;
      val_q  <= val_i;
      scl_q  <= scl_i;
      n_q    <= n_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (ctl_i.cnt_clr) cnt_q <= '0;
    else if (ctl_i.hclr_step || ctl_i.fin_step || ctl_i.sclr_step) cnt_q <= cnt_q + 1'b1;
  end

  // height memory: one port, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.hclr_step) height_mem[cnt_q[EqW-1:0]] <= '0;
    else if (ctl_i.edge_wr) begin
      if (row_q < col_q && hrd_q < (col_q - row_q))
        height_mem[col_q[EqW-1:0]] <= col_q - row_q;
    end
    if (ctl_i.edge_rd) hrd_q <= height_mem[col_q[EqW-1:0]];
    else if (ctl_i.fin_rd) hrd_q <= height_mem[cnt_q[EqW-1:0]];
  end

  // finalize: hrd_q holds height of column cnt, read in the step before
  logic [9:0]  fin_h;
  logic [17:0] fin_sum;
  assign fin_h   = hrd_q;
  assign fin_sum = (cnt_q == '0) ? 18'd1 : ({1'b0, total_q} + 18'(fin_h) + 18'd1);
  assign hnext   = (fin_sum > 18'(LocMax)) ? LocMax : fin_sum[LocW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      psize_q <= '0;
      over_q  <= 1'b0;
    end else begin
      if (ctl_i.fin_init) begin
        total_q <= '0;
        over_q  <= 1'b0;
      end
      if (ctl_i.fin_step) begin
        total_q <= hnext;
        if (32'(fin_sum) > 32'(Depth))
          over_q <= 1'b1;
      end
      if (ctl_i.sclr_step && cnt_q == '0 && mode_q == MODE_FINALIZE)
        psize_q <= (n_q == '0) ? '0 : total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin_step) diag_mem[cnt_q[EqW-1:0]] <= hnext;
    else if (ctl_i.dclr) diag_mem[cnt_q[EqW-1:0]] <= '0;
  end

  // diag reads (two ports)
  logic [9:0] colm1;
  assign colm1 = col_q - 10'd1;
  always_ff @(posedge clk_i) begin
    if (ctl_i.adr_rd) begin
      dcol_q  <= diag_mem[col_q[EqW-1:0]];
      dprev_q <= diag_mem[colm1[EqW-1:0]];
    end
  end

  // address check
  logic signed [19:0] min_row, addr_s;
  assign min_row = (col_q == '0) ? 20'sd0
                 : 20'(signed'({10'b0, col_q})) - (20'(dcol_q) - 20'(dprev_q)) + 20'sd1;
  assign addr_s  = 20'(dcol_q) - 20'sd1 + 20'(row_q) - 20'(col_q);
  always_ff @(posedge clk_i) begin
    if (ctl_i.adr_chk) begin
      outside_q <= (row_q > col_q) || ($signed({10'b0, row_q}) < min_row) ||
                   addr_s < 0 || addr_s >= signed'(20'(psize_q)) ||
                   32'(addr_s) >= 32'(Depth);
      addr_q    <= AdW'(addr_s);
    end
  end

  // multiply then store RMW
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) prod_q <= $signed(val_q) * $signed(scl_q);
  end

  logic signed [49:0] rnd, sum;
  assign rnd = 50'((prod_q + 64'sd32768) >>> 16);
  assign sum = rnd + 50'(signed'(srd_q));

  always_ff @(posedge clk_i) begin
    if (ctl_i.st_rd) srd_q <= store_mem[addr_q];
    if (ctl_i.sclr_step) store_mem[cnt_q[AdW-1:0]] <= '0;
    else if (ctl_i.st_wr)
      store_mem[addr_q] <= (sum > signed'(50'(signed'(VMax)))) ? VMax
                         : (sum < signed'(50'(signed'(VMin)))) ? VMin : sum[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) status_q <= ST_OK;
    else if (ctl_i.set_status) status_q <= ctl_i.status;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (ctl_i.out_load) ovalid_q <= 1'b1;
    else if (out_ready_i) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      ost_q <= status_q;
      ord_q <= (mode_q == MODE_READ && status_q == ST_OK) ? srd_q : '0;
      ot_q  <= psize_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ost_q;
  assign read_o      = ord_q;
  assign total_o     = ot_q;

  assign st_o.cnt_last_h = (cnt_q == CntW'(MaxEq - 1));
  assign st_o.cnt_last_f = (cnt_q >= CntW'(n_q));
  assign st_o.cnt_last_s = (cnt_q == CntW'(Depth - 1));
  assign st_o.range_bad  = (11'(col_q) >= n_q);
  assign st_o.ar_bad     = (11'(col_q) >= n_q) || (11'(row_q) >= n_q);
  assign st_o.scale_zero = (scl_q == '0);
  assign st_o.outside    = outside_q;
  assign st_o.over       = over_q;
  assign st_o.mode       = ctl_i.load ? mode_e'(mode_i) : mode_q;
endmodule

>>> src/skyline_profile_builder_assembler_top.sv
// Skyline profile builder and assembler. Items arrive on the s_axis stream,
// one result per item leaves on m_axis. After reset the block zeroes all
// column heights and diagonal locations, with s_axis_tready low. Per item:
// start clears all column heights; edge reads the column height and raises
// it when the edge reaches higher (an out-of-range column only sets the
// status); finalize reads and sums the column heights one column at a time,
// then clears the whole store one entry a cycle; clear store clears every
// store entry; add is a read-modify-write on the single store port, and read
// reads one store entry; rejected adds and reads finish sooner. A result
// still waiting in the result register holds the item in its last step.
// The store is zero after reset only in effect: the profile size is zero
// until a finalize, and finalize clears the store. One item is in work at
// a time; the result register lets the next item be accepted while a
// result waits.
module skyline_profile_builder_assembler_top #(
  parameter int unsigned MAX_EQUATIONS = spba_pkg::MaxEquations,
  parameter int unsigned PROFILE_DEPTH = spba_pkg::ProfileDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: row_index[9:0], col_index[19:10], entry_value[51:20], scale[83:52]
  input  logic [87:0] s_axis_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], read_value[49:2], profile_total[66:50]
  output logic [71:0] m_axis_tdata
);
  import spba_pkg::*;

  logic [10:0] num_eq_q;
  ctrl_t ctl;
  stat_t st;
  logic [1:0]  status;
  logic [47:0] rdv;
  logic [16:0] total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_eq_q <= '0;
    else if (cfg_we_i) num_eq_q <= cfg_wdata_i;
  end

  spba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (m_axis_tvalid & ~m_axis_tready),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  spba_dpath #(.MaxEq(MAX_EQUATIONS), .Depth(PROFILE_DEPTH)) u_dpath (
    .clk_i, .rst_ni,
    .ctl_i       (ctl),
    .st_o        (st),
    .num_eq_i    (num_eq_q),
    .mode_i      (s_axis_tuser),
    .row_i       (s_axis_tdata[9:0]),
    .col_i       (s_axis_tdata[19:10]),
    .val_i       (s_axis_tdata[51:20]),
    .scl_i       (s_axis_tdata[83:52]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_o    (status),
    .read_o      (rdv),
    .total_o     (total)
  );

  assign m_axis_tdata = {5'b0, total, rdv, status};
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import spba_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam longint V48Max = 64'sd140737488355327;
  localparam longint V48Min = -64'sd140737488355328;

  typedef struct packed {
    status_e     st;
    logic [47:0] rd;
    logic [16:0] tot;
  } result_t;

  // one row of the directed table: either a register write or a transaction
  typedef struct {
    bit          is_cfg;
    logic [10:0] cfgv;
    mode_e       md;
    logic [9:0]  r;
    logic [9:0]  c;
    logic [31:0] v;
    logic [31:0] s;
    bit          typed;
    result_t     want;
  } drow_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  skyline_profile_builder_assembler_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // shadow state of the profile
  logic [10:0]  neq;
  logic [9:0]   col_hgt [MaxEquations];
  logic [16:0]  diag_loc [MaxEquations];
  longint       store_val [int];
  logic [16:0]  prof_size;

  result_t      pending_q [$];
  int           errors;
  int           cycles = 0;
  int           n_sent;
  int           n_checked;
  int           n_mode [8];
  int           n_sat;
  int           n_ovf;
  bit           src_burst;
  bit           snk_burst;
  int           last_r;
  int           last_c;

  function automatic int unsigned eq_n();
    return (neq < MaxEquations) ? neq : MaxEquations;
  endfunction

  // store address of (row, col), or -1 when outside the profile
  function automatic longint locate(int r, int c);
    longint top_row;
    longint addr;
    if (r > c) return -1;
    top_row = (c == 0) ? 0 : longint'(c) - (longint'(diag_loc[c]) - longint'(diag_loc[c-1])) + 1;
    if (r < top_row) return -1;
    addr = longint'(diag_loc[c]) - 1 + r - c;
    if (addr < 0 || addr >= prof_size || addr >= ProfileDepth) return -1;
    return addr;
  endfunction

  function automatic result_t profile_step(mode_e md, logic [9:0] r, logic [9:0] c,
                                           logic signed [31:0] v, logic signed [31:0] s);
    result_t      res;
    int unsigned  n;
    int unsigned  total;
    bit           over;
    longint       addr;
    longint       acc;
    n = eq_n();
    res.st = ST_OK;
    res.rd = '0;
    case (md)
      MODE_START: foreach (col_hgt[j]) col_hgt[j] = '0;
      MODE_EDGE: begin
        if (c >= n) res.st = ST_RANGE;
        else if (r < c && col_hgt[c] < c - r) col_hgt[c] = c - r;
      end
      MODE_FINALIZE: begin
        total = 0;
        over = 1'b0;
        for (int j = 0; j < n; j++) begin
          total = (j == 0) ? 1 : total + col_hgt[j] + 1;
          if (total > ProfileDepth) over = 1'b1;
          if (total > LocMax) total = LocMax;
          diag_loc[j] = total;
        end
        prof_size = (n == 0) ? '0 : total;
        store_val.delete();
        if (over) begin
          res.st = ST_OVERFLOW;
          n_ovf++;
        end
      end
      MODE_ADD: begin
        if (s == 0) res.st = ST_OUTSIDE;
        else if (r >= n || c >= n) res.st = ST_RANGE;
        else begin
          addr = locate(r, c);
          if (addr < 0) res.st = ST_OUTSIDE;
          else begin
            // Q32.32 product, round half up to Q32.16
            acc = (longint'(v) * longint'(s) + 32768) >>> 16;
            acc += store_val.exists(addr) ? store_val[addr] : 0;
            if (acc > V48Max || acc < V48Min) n_sat++;
            if (acc > V48Max) acc = V48Max;
            if (acc < V48Min) acc = V48Min;
            store_val[addr] = acc;
          end
        end
      end
      MODE_CLEAR: store_val.delete();
      MODE_READ: begin
        if (r >= n || c >= n) res.st = ST_RANGE;
        else begin
          addr = locate(r, c);
          if (addr < 0) res.st = ST_OUTSIDE;
          else res.rd = store_val.exists(addr) ? store_val[addr][47:0] : '0;
        end
      end
      default: res.st = ST_OUTSIDE;
    endcase
    res.tot = prof_size;
    return res;
  endfunction

  // source side: random gap, then hold the transaction until taken
  task automatic send(mode_e md, logic [9:0] r, logic [9:0] c, logic [31:0] v,
                      logic [31:0] s, bit typed, result_t want);
    int      gap;
    result_t got;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= {4'b0, s, v, c, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = profile_step(md, r, c, v, s);
    pending_q.push_back(typed ? want : got);
    n_sent++;
    n_mode[md]++;
    if (n_sent % 50 == 0) src_burst = ($urandom_range(0, 3) == 0);
  endtask

  // lets every result arrive, then a short pause before a register write
  task automatic write_neq(logic [10:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    neq = val;
  endtask

  // add or read aimed mostly inside the current profile, with hot entries
  task automatic send_entry(mode_e md);
    int          n;
    int          c;
    int          r;
    longint      span;
    logic [31:0] v;
    logic [31:0] s;
    n = eq_n();
    if (n == 0 || $urandom_range(0, 99) < 15) begin
      r = $urandom_range(0, 1023);
      c = $urandom_range(0, 1023);
    end else if ($urandom_range(0, 99) < 40) begin
      r = last_r;
      c = last_c;
    end else begin
      c = $urandom_range(0, n - 1);
      span = (c == 0) ? 0 : longint'(diag_loc[c]) - longint'(diag_loc[c-1]) - 1;
      if (span < 0 || span > c) span = 0;
      r = c - $urandom_range(0, int'(span));
    end
    last_r = r;
    last_c = c;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 262143) - 131072;
      1: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{$urandom_range(0, 1) == 0}}};
      default: v = $urandom;
    endcase
    s = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
    send(md, r[9:0], c[9:0], v, s, 1'b0, '0);
  endtask

  // result side: random stall before each transaction, then check it
  initial begin
    result_t exp_r;
    result_t act;
    int      gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = snk_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      act.st  = status_e'(m_axis_tdata[1:0]);
      act.rd  = m_axis_tdata[49:2];
      act.tot = m_axis_tdata[66:50];
      n_checked++;
      if (n_checked % 60 == 0) snk_burst = ($urandom_range(0, 3) == 0);
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction: status %0d", act.st);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (act.st !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, act.st);
          errors++;
        end
        if (act.rd !== exp_r.rd) begin
          $error("read_value: expected %h, got %h", exp_r.rd, act.rd);
          errors++;
        end
        if (act.tot !== exp_r.tot) begin
          $error("profile_total: expected %0d, got %0d", exp_r.tot, act.tot);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    drow_t       dir_q [$];
    int          n_cfgs [6];
    int          n_edges;
    int          n_mix;
    int          pick;
    int          c;
    dir_q.push_back('{0, 0, MODE_READ, 0, 0, 0, 0, 1, '{ST_RANGE, 48'd0, 17'd0}});
    dir_q.push_back('{0, 0, MODE_FINALIZE, 0, 0, 0, 0, 1, '{ST_OK, 48'd0, 17'd0}});
    dir_q.push_back('{1, 4, MODE_START, 0, 0, 0, 0, 0, '0});
    dir_q.push_back('{0, 0, MODE_START, 0, 0, 0, 0, 1, '{ST_OK, 48'd0, 17'd0}});
    dir_q.push_back('{0, 0, MODE_EDGE, 0, 3, 0, 0, 1, '{ST_OK, 48'd0, 17'd0}});
    dir_q.push_back('{0, 0, MODE_EDGE, 1, 1, 0, 0, 1, '{ST_OK, 48'd0, 17'd0}});
    dir_q.push_back('{0, 0, MODE_EDGE, 0, 4, 0, 0, 1, '{ST_RANGE, 48'd0, 17'd0}});
    dir_q.push_back('{0, 0, MODE_EDGE, 1023, 1023, 0, 0, 1, '{ST_RANGE, 48'd0, 17'd0}});
    dir_q.push_back('{0, 0, MODE_FINALIZE, 0, 0, 0, 0, 1, '{ST_OK, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_ADD, 3, 3, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0});
    // three most-positive products drive the entry into saturation
    for (int k = 0; k < 3; k++)
      dir_q.push_back('{0, 0, MODE_ADD, 0, 3, 32'h80000000, 32'h80000000, 0, '0});
    dir_q.push_back('{0, 0, MODE_READ, 0, 3, 0, 0, 0, '0});
    dir_q.push_back('{0, 0, MODE_ADD, 1023, 1023, 32'h1, 32'h0, 1, '{ST_OUTSIDE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_ADD, 1023, 0, 32'h1, 32'h1, 1, '{ST_RANGE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_ADD, 2, 1, 32'h1, 32'h1, 1, '{ST_OUTSIDE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_ADD, 0, 2, 32'h1, 32'h1, 1, '{ST_OUTSIDE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_READ, 1023, 1023, 0, 0, 1, '{ST_RANGE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_RSVD6, 0, 0, 0, 0, 1, '{ST_OUTSIDE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_RSVD7, 0, 0, 0, 0, 1, '{ST_OUTSIDE, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_ADD, 3, 3, 32'h80000000, 32'h7FFFFFFF, 0, '0});
    dir_q.push_back('{0, 0, MODE_READ, 3, 3, 0, 0, 0, '0});
    dir_q.push_back('{0, 0, MODE_CLEAR, 0, 0, 0, 0, 1, '{ST_OK, 48'd0, 17'd7}});
    dir_q.push_back('{0, 0, MODE_READ, 3, 3, 0, 0, 1, '{ST_OK, 48'd0, 17'd7}});

    // known values on every input from time zero
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_START;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_sat = 0;
    n_ovf = 0;
    src_burst = 1'b0;
    snk_burst = 1'b0;
    last_r = 0;
    last_c = 0;
    foreach (n_mode[k]) n_mode[k] = 0;
    neq = '0;
    prof_size = '0;
    foreach (col_hgt[j]) col_hgt[j] = '0;
    foreach (diag_loc[j]) diag_loc[j] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) write_neq(dir_q[i].cfgv);
      else send(dir_q[i].md, dir_q[i].r, dir_q[i].c, dir_q[i].v, dir_q[i].s,
                dir_q[i].typed, dir_q[i].want);
    end

    // random phases: column count beyond the limit, tiny, full size with an
    // overflowing profile, none at all, a single column, and a middling one
    n_cfgs = '{2047, 3, 1024, 0, 1, 60};
    foreach (n_cfgs[ph]) begin
      write_neq(n_cfgs[ph]);
      send(MODE_START, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
      n_edges = (ph == 2) ? 300 : 40;
      for (int k = 0; k < n_edges; k++) begin
        c = (eq_n() == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, eq_n() - 1);
        send(MODE_EDGE, (ph == 2) ? 10'd0 : 10'($urandom_range(0, c)), c[9:0],
             $urandom, $urandom, 1'b0, '0);
      end
      send(MODE_FINALIZE, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
      n_mix = (ph == 2) ? 110 : 190;
      for (int k = 0; k < n_mix; k++) begin
        pick = $urandom_range(0, 99);
        if ((ph == 1 || ph == 5) && k == n_mix / 2)
          send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        else if (pick < 55) send_entry(MODE_ADD);
        else if (pick < 87) send_entry(MODE_READ);
        else if (pick < 93) send(MODE_EDGE, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        else if (pick < 95) send(MODE_START, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        else send(mode_e'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom,
                  1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d transactions (start %0d, edge %0d, finalize %0d, add %0d, clear %0d,",
             n_sent, n_mode[0], n_mode[1], n_mode[2], n_mode[3], n_mode[4]);
    $display("  read %0d, reserved %0d); %0d saturating adds, %0d overflowing profiles",
             n_mode[5], n_mode[6] + n_mode[7], n_sat, n_ovf);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/spba_pkg.sv
src/spba_ctrl.sv
src/spba_dpath.sv
src/skyline_profile_builder_assembler_top.sv
tb/tb.sv
